// File: sv/midi_track_event_encoder_defines.svh
// Assertion macros shared by the MIDI track event encoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH
`define MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mte_pkg.sv
// Shared constants and types of the MIDI track event encoder.
// Depends on nothing; imported by the channel cell, the controller and the top level.
`default_nettype none

package mte_pkg;

  // Channel table size and index width.
  localparam int NUM_CHANNELS = 16;
  localparam int CH_W = $clog2(NUM_CHANNELS);

  // Variable-length quantity limits.
  localparam int VLQ_MAX_BYTES = 4;
  localparam int VLQ_BITS = 7 * VLQ_MAX_BYTES;
  localparam int VLQ_K_W = (VLQ_MAX_BYTES > 1) ? $clog2(VLQ_MAX_BYTES) : 1;

  // Field and state widths.
  localparam int TICK_W = 28;
  localparam int INSTR_W = 8;
  localparam int NOTE_W = 7;
  localparam int CNT_W = 15;
  localparam int BCNT_W = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7fff;
  localparam logic [TICK_W-1:0] VLQ_LIMIT = TICK_W'((64'd1 << VLQ_BITS) - 64'd1);

  // Message bytes.
  localparam logic [7:0] VLQ_CONT = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7f;
  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
  localparam logic [7:0] STATUS_PROGRAM = 8'hc0;
  localparam logic [7:0] META_STATUS = 8'hff;
  localparam logic [7:0] META_END_TRACK = 8'h2f;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // Search token that travels along the row of channel cells.
  typedef struct packed {
    logic            vld;
    logic            found;
    logic [CNT_W-1:0] low;
    logic [CH_W-1:0] pick;
  } tok_t;

  // Table update broadcast to all cells at the end of a search.
  typedef struct packed {
    logic               en;
    logic               new_ent;
    logic [CH_W-1:0]    idx;
    logic [INSTR_W-1:0] instr;
  } upd_t;

endpackage

`default_nettype wire

// File: sv/mte_cell.sv
// One channel table entry with its stage of the search token chain.
// Depends on mte_pkg.
`default_nettype none

module mte_cell
  import mte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [CH_W-1:0]    cell_idx_i,
  input  wire logic [INSTR_W-1:0] instr_i,
  input  wire tok_t               tok_i,
  output tok_t                    tok_o,
  input  wire upd_t               upd_i
);

  logic [INSTR_W-1:0] inst_q, inst_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  tok_t               tok_q, tok_d;

  // Search step: first matching entry wins, else track the strictly lowest count.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.found) begin
      if (inst_q == instr_i) begin
        tok_d.found = 1'b1;
        tok_d.pick  = cell_idx_i;
      end else if (cnt_q < tok_i.low) begin
        tok_d.low  = cnt_q;
        tok_d.pick = cell_idx_i;
      end
    end
  end

  // Entry update when this cell is the chosen channel.
  always_comb begin
    inst_d = inst_q;
    cnt_d  = cnt_q;
    if (upd_i.en && (upd_i.idx == cell_idx_i)) begin
      if (upd_i.new_ent) begin
        inst_d = upd_i.instr;
        cnt_d  = CNT_W'(1);
      end else if (cnt_q < COUNT_MAX) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inst_q <= '0;
      cnt_q  <= '0;
      tok_q  <= '0;
    end else begin
      inst_q <= inst_d;
      cnt_q  <= cnt_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: sv/mte_ctrl.sv
// Sequencer of the MIDI track event encoder: input transaction, search launch,
// byte emission and the output register. Depends on mte_pkg and the defines header.
`default_nettype none

`include "midi_track_event_encoder_defines.svh"

module mte_ctrl
  import mte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic [TICK_W-1:0]  event_tick_i,
  input  wire logic [INSTR_W-1:0] instrument_i,
  input  wire logic [NOTE_W-1:0]  pitch_i,
  input  wire logic [NOTE_W-1:0]  velocity_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    last_o,
  output logic [BCNT_W-1:0]       track_bytes_o,
  output logic [INSTR_W-1:0]      instr_o,
  output tok_t                    tok_o,
  input  wire tok_t               tok_i,
  output upd_t                    upd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEARCH   = 4'd1;
  localparam logic [3:0] ST_PC_DELTA = 4'd2;
  localparam logic [3:0] ST_PC_STAT  = 4'd3;
  localparam logic [3:0] ST_PC_PROG  = 4'd4;
  localparam logic [3:0] ST_NT_DELTA = 4'd5;
  localparam logic [3:0] ST_NT_STAT  = 4'd6;
  localparam logic [3:0] ST_NT_PITCH = 4'd7;
  localparam logic [3:0] ST_NT_VEL   = 4'd8;
  localparam logic [3:0] ST_END      = 4'd9;

  // Index of the most significant nonzero VLQ group.
  function automatic logic [VLQ_K_W-1:0] vlq_top(input logic [VLQ_BITS-1:0] v);
    logic [VLQ_K_W-1:0] k;
    k = '0;
    for (int j = 1; j < VLQ_MAX_BYTES; j++) begin
      if ((v >> (7 * j)) != '0) k = VLQ_K_W'(j);
    end
    return k;
  endfunction

  // Seven-bit group k of a VLQ value.
  function automatic logic [6:0] vlq_group(input logic [VLQ_BITS-1:0] v,
                                           input logic [VLQ_K_W-1:0] k);
    logic [6:0] g;
    g = '0;
    for (int j = 0; j < VLQ_MAX_BYTES; j++) begin
      if (k == VLQ_K_W'(j)) g = v[7*j +: 7];
    end
    return g;
  endfunction

  logic [3:0]          state_q, state_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [VLQ_BITS-1:0] delta_q, delta_d;
  logic [VLQ_K_W-1:0]  k_q, k_d;
  logic [1:0]          eidx_q, eidx_d;
  logic [INSTR_W-1:0]  instr_q, instr_d;
  logic [NOTE_W-1:0]   pitch_q, pitch_d;
  logic [NOTE_W-1:0]   vel_q, vel_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic                start_q, start_d;
  logic                ovld_q, ovld_d;
  logic [7:0]          obyte_q, obyte_d;
  logic                olast_q, olast_d;
  logic [BCNT_W-1:0]   otrk_q, otrk_d;

  logic                accept;
  logic                slot_free;
  logic                emit;
  logic [7:0]          ebyte;
  logic                elast;
  logic [TICK_W-1:0]   diff;
  logic [TICK_W-1:0]   diff_sat;
  logic [7:0]          vlq_byte;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !ovld_q || !out_stall_i;

  // Clamped and saturated delta of the incoming event.
  assign diff     = (event_tick_i >= tick_q) ? (event_tick_i - tick_q) : '0;
  assign diff_sat = (diff > VLQ_LIMIT) ? VLQ_LIMIT : diff;

  assign vlq_byte = {(k_q != '0), vlq_group(delta_q, k_q)};

  // Sequencer: one byte per free output slot.
  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    bcnt_d  = bcnt_q;
    delta_d = delta_q;
    k_d     = k_q;
    eidx_d  = eidx_q;
    instr_d = instr_q;
    pitch_d = pitch_q;
    vel_d   = vel_q;
    ch_d    = ch_q;
    start_d = 1'b0;
    emit    = 1'b0;
    ebyte   = BYTE_ZERO;
    elast   = 1'b0;
    upd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i) begin
            eidx_d  = '0;
            state_d = ST_END;
          end else begin
            delta_d = VLQ_BITS'(diff_sat);
            k_d     = vlq_top(VLQ_BITS'(diff_sat));
            tick_d  = event_tick_i;
            instr_d = instrument_i;
            pitch_d = pitch_i;
            vel_d   = velocity_i;
            start_d = 1'b1;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tok_i.vld) begin
          upd_o.en      = 1'b1;
          upd_o.new_ent = !tok_i.found;
          upd_o.idx     = tok_i.pick;
          upd_o.instr   = instr_q;
          ch_d          = tok_i.pick;
          state_d       = tok_i.found ? ST_NT_DELTA : ST_PC_DELTA;
        end
      end
      ST_PC_DELTA, ST_NT_DELTA: begin
        if (slot_free) begin
          emit  = 1'b1;
          ebyte = vlq_byte;
          if (k_q == '0) begin
            state_d = (state_q == ST_PC_DELTA) ? ST_PC_STAT : ST_NT_STAT;
          end else begin
            k_d = k_q - VLQ_K_W'(1);
          end
        end
      end
      ST_PC_STAT: begin
        if (slot_free) begin
          emit    = 1'b1;
          ebyte   = STATUS_PROGRAM | 8'(ch_q);
          state_d = ST_PC_PROG;
        end
      end
      ST_PC_PROG: begin
        if (slot_free) begin
          emit    = 1'b1;
          ebyte   = instr_q - 8'd1;
          delta_d = '0;
          k_d     = '0;
          state_d = ST_NT_DELTA;
        end
      end
      ST_NT_STAT: begin
        if (slot_free) begin
          emit    = 1'b1;
          ebyte   = STATUS_NOTE_ON | 8'(ch_q);
          state_d = ST_NT_PITCH;
        end
      end
      ST_NT_PITCH: begin
        if (slot_free) begin
          emit    = 1'b1;
          ebyte   = 8'(pitch_q) & DATA_MASK;
          state_d = ST_NT_VEL;
        end
      end
      ST_NT_VEL: begin
        if (slot_free) begin
          emit    = 1'b1;
          ebyte   = 8'(vel_q) & DATA_MASK;
          elast   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_END: begin
        if (slot_free) begin
          emit = 1'b1;
          case (eidx_q)
            2'd1:    ebyte = META_STATUS;
            2'd2:    ebyte = META_END_TRACK;
            default: ebyte = BYTE_ZERO;
          endcase
          eidx_d = eidx_q + 2'd1;
          if (eidx_q == 2'd3) begin
            elast   = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte count; the end-of-track meta event restarts the track.
    if (emit) begin
      bcnt_d = bcnt_q + BCNT_W'(1);
      if (elast && (state_q == ST_END)) begin
        bcnt_d = '0;
        tick_d = '0;
      end
    end
  end

  // Output register parts the sequencer from the receiver.
  always_comb begin
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    otrk_d  = otrk_q;
    if (emit) begin
      ovld_d  = 1'b1;
      obyte_d = ebyte;
      olast_d = elast;
      otrk_d  = bcnt_q + BCNT_W'(1);
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      bcnt_q  <= '0;
      start_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      bcnt_q  <= bcnt_d;
      start_q <= start_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    k_q     <= k_d;
    eidx_q  <= eidx_d;
    instr_q <= instr_d;
    pitch_q <= pitch_d;
    vel_q   <= vel_d;
    ch_q    <= ch_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    otrk_q  <= otrk_d;
  end

  // Search token enters the first cell in the cycle after the transaction.
  always_comb begin
    tok_o       = '0;
    tok_o.vld   = start_q;
    tok_o.found = 1'b0;
    tok_o.low   = COUNT_MAX;
    tok_o.pick  = CH_W'(NUM_CHANNELS - 1);
  end

  assign instr_o       = instr_q;
  assign out_valid_o   = ovld_q;
  assign out_byte_o    = obyte_q;
  assign last_o        = olast_q;
  assign track_bytes_o = otrk_q;

  // Checks on the sequencer.
  `MTE_ASSERT_NOW(a_tok_in_search, clk_i, rst_ni, tok_i.vld, state_q == ST_SEARCH, "search token outside search")
  `MTE_ASSERT_NEXT(a_upd_once, clk_i, rst_ni, upd_o.en, (state_q == ST_PC_DELTA) || (state_q == ST_NT_DELTA), "table update not followed by delta")
  `MTE_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, emit && elast, state_q == ST_IDLE, "final byte did not end the sequence")
  `MTE_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, emit && elast && (state_q == ST_END), (bcnt_q == '0) && (tick_q == '0), "end of track did not clear time and count")
  `MTE_ASSERT_NOW(a_no_emit_busy, clk_i, rst_ni, emit, slot_free, "byte emitted into a full output register")

endmodule

`default_nettype wire

// File: sv/midi_track_event_encoder.sv
// MIDI track event encoder.
//
// Input channel (in_valid_i / in_stall_o): one transaction is a note event
// (action 0: absolute tick, instrument, pitch, velocity) or an end of track
// (action 1). Output channel (out_valid_o / out_stall_i): one transaction is
// one track byte with last_o on the final byte of its input and track_bytes_o,
// the running byte count of the track including that byte.
// A note event walks a search token along a row of NUM_CHANNELS channel cells,
// one cell per cycle, so the channel is known once the token leaves the last
// cell. Then one byte leaves per cycle while the receiver does not stall:
// 4 to 7 bytes without a program change, 7 to 10 with one.
// The next input is taken once the final byte sits in the output register.
// Reset clears the channel table, the tick and the byte count; no clearing pass.
// While the receiver stalls, the output register holds its byte and the
// sequencer waits for the slot.
// Depends on mte_pkg, mte_cell and mte_ctrl.
`default_nettype none

module midi_track_event_encoder
  import mte_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic [TICK_W-1:0]  event_tick_i,
  input  wire logic [INSTR_W-1:0] instrument_i,
  input  wire logic [NOTE_W-1:0]  pitch_i,
  input  wire logic [NOTE_W-1:0]  velocity_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    last_o,
  output logic [BCNT_W-1:0]       track_bytes_o
);

  tok_t               tok [NUM_CHANNELS+1];
  upd_t               upd;
  logic [INSTR_W-1:0] instr;

  // Sequencer and output register.
  mte_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .event_tick_i  (event_tick_i),
    .instrument_i  (instrument_i),
    .pitch_i       (pitch_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .track_bytes_o (track_bytes_o),
    .instr_o       (instr),
    .tok_o         (tok[0]),
    .tok_i         (tok[NUM_CHANNELS]),
    .upd_o         (upd)
  );

  // Row of channel cells; the token moves one cell per cycle.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    mte_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CH_W'(i)),
      .instr_i    (instr),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .upd_i      (upd)
    );
  end

endmodule

`default_nettype wire
